// ----- src/arpt_pkg.sv -----
// arpt_pkg: shared types and constants for the address range partition table.
// No dependencies.
`timescale 1ns / 1ps
package arpt_pkg;
  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_APPEND = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_MAXGAP = 3'd3,
    CMD_FIT    = 3'd4
  } cmd_t;

  // Unused command code; the engine also parks a refused append on it.
  localparam logic [2:0] CMD_SKIP = 3'd7;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_REJECT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_WAIT,
    ENG_SCAN,
    ENG_TAIL,
    ENG_DONE
  } eng_state_t;

  localparam logic [7:0] HOLE_CODE = 8'd45;
endpackage

// ----- src/address_range_partition_table_unit.sv -----
// Channel  | Direction | Handshake          | Payload
// input    | in        | push / full        | command first_addr second_addr fit_length owner_code
// result   | out       | pop / empty        | status owner_out value_out
// config   | in        | cfg_valid/cfg_ready| cfg_data (span end)
//
// Lookup, max gap and first fit are walked by the engine with one table RAM
// read per slot; lookup and first fit stop at the first match. An append that
// also opens a hole writes the hole entry before its own. A full result queue
// adds its stall.
// Reset (synchronous rst) empties the table and the queues and restores
// the span end to 2^ADDR_BITS; no clearing pass is needed.
// The input queue holds two items and the result queue two results, so each
// side stalls on its own.
// Depends on arpt_pkg, arpt_queue, arpt_engine, arpt_ram.
`timescale 1ns / 1ps
module address_range_partition_table_unit
  import arpt_pkg::*;
#(
  parameter int MAX_SLOTS = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         command,
  input  logic [ADDR_BITS-1:0] first_addr,
  input  logic [ADDR_BITS:0] second_addr,
  input  logic [ADDR_BITS:0] fit_length,
  input  logic [7:0]         owner_code,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         status,
  output logic [7:0]         owner_out,
  output logic [ADDR_BITS:0] value_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ADDR_BITS:0] cfg_data
);
  localparam int IN_W  = 3 + ADDR_BITS + 2 * (ADDR_BITS + 1) + 8;
  localparam int OUT_W = 2 + 8 + ADDR_BITS + 1;
  localparam logic [ADDR_BITS:0] CAP = {1'b1, {ADDR_BITS{1'b0}}};

  logic [ADDR_BITS:0] span_end, lim;
  logic [IN_W-1:0]    q_data;
  logic               q_empty, take;
  logic [2:0]         e_cmd;
  logic [ADDR_BITS-1:0] e_a;
  logic [ADDR_BITS:0] e_b, e_len;
  logic [7:0]         e_own;
  logic               r_valid, r_full;
  logic [1:0]         r_st;
  logic [7:0]         r_ow;
  logic [ADDR_BITS:0] r_val;

  // Register accepts writes at any time; callers must write only while idle (the block does not enforce it).
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) span_end <= CAP;
    else if (cfg_valid) span_end <= cfg_data;
  end
  // Clamp an oversized domain to the address space.
  assign lim = (span_end > CAP) ? CAP : span_end;

  arpt_queue #(.WIDTH(IN_W)) u_in_q (
    .clk, .rst, .wr(push), .wdata({command, first_addr, second_addr, fit_length, owner_code}),
    .full, .rd(take), .rdata(q_data), .empty(q_empty)
  );
  assign {e_cmd, e_a, e_b, e_len, e_own} = q_data;

  arpt_engine #(.MAX_SLOTS(MAX_SLOTS), .ADDR_BITS(ADDR_BITS)) u_engine (
    .clk, .rst, .cmd_valid(!q_empty), .cmd_take(take), .cmd(e_cmd), .a_in(e_a),
    .b_in(e_b), .len_in(e_len), .own_in(e_own), .lim, .res_valid(r_valid),
    .res_full(r_full), .res_status(r_st), .res_owner(r_ow), .res_value(r_val)
  );

  arpt_queue #(.WIDTH(OUT_W)) u_out_q (
    .clk, .rst, .wr(r_valid), .wdata({r_st, r_ow, r_val}), .full(r_full),
    .rd(pop), .rdata({status, owner_out, value_out}), .empty
  );
endmodule

// ----- src/arpt_ram.sv -----
// arpt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module arpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/arpt_queue.sv -----
// arpt_queue: two-entry queue, used on both the command side and the result side of the engine.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps
module arpt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  logic [WIDTH-1:0] ent [2];
  logic             rptr, wptr;
  logic [1:0]       cnt;

  assign full  = cnt == 2'd2;
  assign empty = cnt == 2'd0;
  assign rdata = ent[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      ent[wptr] <= wdata;
    end
    if (rst) begin
      rptr <= 1'b0;
      wptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (wr && !full) begin
        wptr <= ~wptr;
      end
      if (rd && !empty) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(wr && !full) - 2'(rd && !empty);
    end
  end
endmodule

// ----- src/arpt_engine.sv -----
// arpt_engine: back end that executes commands against the slot table.
// Depends on arpt_pkg and arpt_ram.
`timescale 1ns / 1ps
module arpt_engine
  import arpt_pkg::*;
#(
  parameter int MAX_SLOTS = 64,
  parameter int ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  logic [2:0]         cmd,
  input  logic [ADDR_BITS-1:0] a_in,
  input  logic [ADDR_BITS:0] b_in,
  input  logic [ADDR_BITS:0] len_in,
  input  logic [7:0]         own_in,
  input  logic [ADDR_BITS:0] lim,
  output logic               res_valid,
  input  logic               res_full,
  output logic [1:0]         res_status,
  output logic [7:0]         res_owner,
  output logic [ADDR_BITS:0] res_value
);
  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int EW = 2 * ADDR_BITS + 8;

  eng_state_t state, state_next;
  logic [2:0]           op;
  logic [ADDR_BITS-1:0] a;
  logic [ADDR_BITS:0]   b, len, best;
  logic [7:0]           own;
  logic [CW-1:0]        slot_count, idx;
  logic [ADDR_BITS:0]   next_unclaimed;
  logic                 found;
  logic [1:0]           st;
  logic [7:0]           ow;

  logic                 we;
  logic [IW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic                 hole_stage;

  logic [ADDR_BITS-1:0] r_first, r_last;
  logic [7:0]           r_own;
  logic [ADDR_BITS:0]   r_end, c_end, hsize, fb, fe;
  logic                 fit_ok, hit;
  logic [ADDR_BITS:0]   t_e, t_b;
  logic                 tail_ok;
  logic [ADDR_BITS:0]   tail_size;
  logic [CW:0]          need_sum;
  logic                 app_bad;

  arpt_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign {r_first, r_last, r_own} = rdata;
  assign r_end  = {1'b0, r_last} + 1'b1;
  assign c_end  = (r_end > lim) ? lim : r_end;
  assign hsize  = ({1'b0, r_first} < c_end) ? c_end - {1'b0, r_first} : '0;
  assign fb     = ({1'b0, a} > {1'b0, r_first}) ? {1'b0, a} : {1'b0, r_first};
  assign fe     = (b < r_end) ? b : r_end;
  assign fit_ok = (fb < fe) && (len <= fe - fb);
  assign hit    = (a >= r_first) && (a <= r_last);

  assign t_b       = ({1'b0, a} > next_unclaimed) ? {1'b0, a} : next_unclaimed;
  assign t_e       = (b < lim) ? b : lim;
  assign tail_ok   = (t_b < t_e) && (len <= t_e - t_b);
  assign tail_size = (next_unclaimed < lim) ? lim - next_unclaimed : '0;

  assign need_sum = {1'b0, slot_count}
                    + (({1'b0, a} > next_unclaimed) ? (CW+1)'(2) : (CW+1)'(1));
  assign app_bad  = ({1'b0, a} < next_unclaimed) || ({1'b0, a} >= b) || (b > lim)
                    || (own == HOLE_CODE);

  assign raddr = idx[IW-1:0];
  assign we    = (state == ENG_SCAN) && (op == CMD_APPEND);
  assign waddr = slot_count[IW-1:0];
  assign wdata = hole_stage
      ? {next_unclaimed[ADDR_BITS-1:0], ADDR_BITS'(a - 1'b1), HOLE_CODE}
      : {a, ADDR_BITS'(b - 1'b1), own};

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE: if (cmd_valid) state_next = ENG_WAIT;
      ENG_WAIT: state_next = ENG_SCAN;
      ENG_SCAN: begin
        if (op == CMD_APPEND) begin
          if (!hole_stage) state_next = ENG_DONE;
        end else if (!(op inside {CMD_LOOKUP, CMD_MAXGAP, CMD_FIT})) begin
          state_next = ENG_DONE;
        end else if (found || idx >= slot_count) begin
          state_next = ENG_TAIL;
        end
      end
      ENG_TAIL: state_next = ENG_DONE;
      ENG_DONE: if (!res_full) state_next = ENG_IDLE;
      default:  state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    cmd_take  = (state == ENG_IDLE) && cmd_valid;
    res_valid = (state == ENG_DONE);
  end

  assign res_status = st;
  assign res_owner  = ow;
  assign res_value  = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ENG_IDLE;
      slot_count     <= '0;
      next_unclaimed <= '0;
    end else begin
      state <= state_next;
      if (state == ENG_IDLE && cmd_valid) begin
        op <= cmd; a <= a_in; b <= b_in; len <= len_in; own <= own_in;
        idx <= '0; found <= 1'b0; best <= '0; st <= ST_OK; ow <= '0;
        hole_stage <= 1'b0;
      end
      if (state == ENG_WAIT) begin
        // Decide the command; the first table read is now in flight.
        case (op)
          CMD_CLEAR: begin
            slot_count <= '0; next_unclaimed <= '0; found <= 1'b1;
          end
          CMD_APPEND: begin
            if (app_bad) begin
              st <= ST_REJECT; op <= CMD_SKIP;
            end else if (need_sum > (CW+1)'(MAX_SLOTS)) begin
              st <= ST_FULL; op <= CMD_SKIP;
            end else begin
              hole_stage <= {1'b0, a} > next_unclaimed;
            end
          end
          CMD_LOOKUP: begin
            if ({1'b0, a} >= lim) begin
              st <= ST_NONE; found <= 1'b1; idx <= slot_count;
            end else begin
              ow <= HOLE_CODE; idx <= idx + 1'b1;
            end
          end
          CMD_MAXGAP: idx <= idx + 1'b1;
          CMD_FIT: begin
            if (len == '0 || {1'b0, a} >= b || b > lim) begin
              st <= ST_NONE; found <= 1'b1;
            end else begin
              idx <= idx + 1'b1;
            end
          end
          default: st <= ST_REJECT;
        endcase
      end
      if (state == ENG_SCAN) begin
        if (op == CMD_APPEND) begin
          slot_count <= slot_count + 1'b1;
          hole_stage <= 1'b0;
          if (!hole_stage) next_unclaimed <= b;
        end else if (!found && idx - 1'b1 < slot_count && idx != '0) begin
          // rdata holds entry idx-1.
          case (op)
            CMD_LOOKUP: if (hit) begin ow <= r_own; found <= 1'b1; end
            CMD_MAXGAP: if (r_own == HOLE_CODE && hsize > best) best <= hsize;
            CMD_FIT: if (r_own == HOLE_CODE && fit_ok) begin
              best <= fb; found <= 1'b1;
            end
            default: ;
          endcase
          idx <= idx + 1'b1;
        end
      end
      if (state == ENG_TAIL) begin
        case (op)
          CMD_MAXGAP: if (tail_size > best) best <= tail_size;
          CMD_FIT: if (!found) begin
            if (tail_ok) best <= t_b;
            else st <= ST_NONE;
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ----- src/arpt_checker.sv -----
// arpt_checker: port-level checks on the partition table unit, bound to the top.
// Depends on arpt_pkg.
`timescale 1ns / 1ps
module arpt_checker
  import arpt_pkg::*;
#(
  parameter int ADDR_BITS = 48
) (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [1:0]         status,
  input logic [7:0]         owner_out,
  input logic [ADDR_BITS:0] value_out
);
  a_rst_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
      !empty && !pop |=> !empty && $stable(status) && $stable(value_out))
    else $error("waiting result changed");
  a_owner_zero: assert property (@(posedge clk) disable iff (rst)
      !empty && status != ST_OK |-> owner_out == 8'd0)
    else $error("owner on failed command");
  a_full_value: assert property (@(posedge clk) disable iff (rst)
      !empty && status != ST_OK |-> value_out == '0)
    else $error("value on failed command");
endmodule

bind address_range_partition_table_unit arpt_checker #(.ADDR_BITS(ADDR_BITS)) u_chk (
  .clk, .rst, .full, .empty, .pop, .status, .owner_out, .value_out
);

// ----- bench/tb_address_range_partition_table_unit.sv -----
// Self-checking bench for address_range_partition_table_unit: directed and random
// append/lookup/gap/fit streams are scored against an in-bench table predictor.
// Depends on arpt_pkg and the unit under test.
`timescale 1ns / 1ps
module tb_address_range_partition_table_unit;
  import arpt_pkg::*;

  localparam int SLOTS = 64;
  localparam logic [48:0] ADDR_CAP = 49'h1_0000_0000_0000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] CMD_BOGUS = 3'd6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [2:0]  command = '0;
  logic [47:0] first_addr = '0;
  logic [48:0] second_addr = '0;
  logic [48:0] fit_length = '0;
  logic [7:0]  owner_code = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  status;
  logic [7:0]  owner_out;
  logic [48:0] value_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [48:0] cfg_data = '0;

  address_range_partition_table_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .command(command),
    .first_addr(first_addr), .second_addr(second_addr), .fit_length(fit_length),
    .owner_code(owner_code), .empty(empty), .pop(pop), .status(status),
    .owner_out(owner_out), .value_out(value_out), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  typedef struct packed {
    logic [1:0]  st;
    logic [7:0]  own;
    logic [48:0] val;
  } answer_t;

  // Shadow copy of the partition table
  logic [47:0] tbl_first [SLOTS];
  logic [47:0] tbl_last [SLOTS];
  logic [7:0]  tbl_owner [SLOTS];
  int          tbl_count = 0;
  logic [48:0] tbl_next = '0;
  logic [48:0] tbl_end = ADDR_CAP;

  answer_t pending_answers[$];
  bit      failed = 1'b0;
  bit      rx_calm = 1'b0;   // no random pop gaps when set
  bit      tx_calm = 1'b0;   // no random push gaps when set
  int      rx_hold = 0;      // receiver hold-off, counted in cycles
  int      hold_req = 0;     // bump to ask the receiver for a long hold-off
  int      hold_ack = 0;
  int      idle_cycles = 0;

  function automatic logic [48:0] clip_end();
    return (tbl_end > ADDR_CAP) ? ADDR_CAP : tbl_end;
  endfunction

  // Advance the shadow table by one command and return the expected answer.
  function automatic answer_t table_step(logic [2:0] cmd, logic [47:0] a, logic [48:0] b,
                                         logic [48:0] len, logic [7:0] own);
    answer_t r;
    logic [48:0] lim, best, s, lo, hi, he;
    bit found;
    r = '0;
    lim = clip_end();
    found = 0;
    case (cmd)
      CMD_CLEAR: begin
        tbl_count = 0;
        tbl_next = '0;
      end
      CMD_APPEND: begin
        if ({1'b0, a} < tbl_next || {1'b0, a} >= b || b > lim || own == HOLE_CODE) begin
          r.st = ST_REJECT;
        end else if (tbl_count + (({1'b0, a} > tbl_next) ? 2 : 1) > SLOTS) begin
          r.st = ST_FULL;
        end else begin
          if ({1'b0, a} > tbl_next) begin
            tbl_first[tbl_count] = tbl_next[47:0];
            tbl_last[tbl_count] = a - 48'd1;
            tbl_owner[tbl_count] = HOLE_CODE;
            tbl_count++;
          end
          tbl_first[tbl_count] = a;
          tbl_last[tbl_count] = 48'(b - 49'd1);
          tbl_owner[tbl_count] = own;
          tbl_count++;
          tbl_next = b;
        end
      end
      CMD_LOOKUP: begin
        if ({1'b0, a} >= lim) begin
          r.st = ST_NONE;
        end else begin
          r.own = HOLE_CODE;
          for (int i = 0; i < tbl_count; i++)
            if (a >= tbl_first[i] && a <= tbl_last[i]) begin
              r.own = tbl_owner[i];
              break;
            end
        end
      end
      CMD_MAXGAP: begin
        best = '0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_owner[i] != HOLE_CODE) continue;
          he = {1'b0, tbl_last[i]} + 49'd1;
          if (he > lim) he = lim;
          s = ({1'b0, tbl_first[i]} < he) ? he - tbl_first[i] : '0;
          if (s > best) best = s;
        end
        s = (tbl_next < lim) ? lim - tbl_next : '0;
        if (s > best) best = s;
        r.val = best;
      end
      CMD_FIT: begin
        if (len == 0 || {1'b0, a} >= b || b > lim) begin
          r.st = ST_NONE;
        end else begin
          // Scan holes in order, then the trailing hole (index tbl_count)
          for (int i = 0; i <= tbl_count && !found; i++) begin
            if (i < tbl_count) begin
              if (tbl_owner[i] != HOLE_CODE) continue;
              lo = tbl_first[i];
              he = {1'b0, tbl_last[i]} + 49'd1;
            end else begin
              lo = tbl_next;
              he = lim;
            end
            if ({1'b0, a} > lo) lo = a;
            hi = (b < he) ? b : he;
            if (lo < hi && len <= hi - lo) begin
              found = 1;
              r.val = lo;
            end
          end
          if (!found) r.st = ST_NONE;
        end
      end
      default: r.st = ST_REJECT;
    endcase
    return r;
  endfunction

  // Offer one item until the transfer, with random gaps before it.
  task automatic send_item(logic [2:0] cmd, logic [47:0] a, logic [48:0] b,
                           logic [48:0] len, logic [7:0] own);
    int gap;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    command <= cmd;
    first_addr <= a;
    second_addr <= b;
    fit_length <= len;
    owner_code <= own;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_answers.insert(pending_answers.size(), table_step(cmd, a, b, len, own));
  endtask

  // Drop push after the last transfer of a test, then drain.
  task automatic drain();
    push <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_domain_end(logic [48:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tbl_end = v;
  endtask

  // Result side: pop with random stalls; score each transfer.
  always @(posedge clk) begin
    answer_t exp_a;
    if (!rst && pop && !empty) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result st=%0d own=%0d val=%0h", $time,
                 status, owner_out, value_out);
        failed = 1'b1;
      end else begin
        exp_a = pending_answers.pop_front();
        if (status !== exp_a.st) begin
          $display("%0t: status exp %0d got %0d", $time, exp_a.st, status);
          failed = 1'b1;
        end
        if (owner_out !== exp_a.own) begin
          $display("%0t: owner_out exp %0d got %0d", $time, exp_a.own, owner_out);
          failed = 1'b1;
        end
        if (value_out !== exp_a.val) begin
          $display("%0t: value_out exp %0h got %0h", $time, exp_a.val, value_out);
          failed = 1'b1;
        end
      end
    end
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      rx_hold <= LONG_HOLD;
      pop <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      pop <= 1'b0;
    end else if (!rx_calm && $urandom_range(0, 9) == 0) begin
      rx_hold <= $urandom_range(0, 6);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog: count cycles with no transfer on any channel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [48:0] rand49();
    return {1'($urandom_range(0, 1)), $urandom(), 16'($urandom_range(0, 65535))};
  endfunction

  function automatic logic [7:0] rand_owner();
    logic [7:0] o;
    o = 8'($urandom_range(0, 255));
    return (o == HOLE_CODE) ? 8'd46 : o;
  endfunction

  // Extremes of every field, every command and the named corner cases.
  task automatic test_directed();
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_MAXGAP, '0, '0, '0, '0);
    send_item(CMD_FIT, '0, ADDR_CAP, ADDR_CAP, '0);
    send_item(CMD_FIT, 48'd5, 49'd5, 49'd1, '0);          // empty window
    send_item(CMD_FIT, 48'd0, 49'd9, 49'd0, '0);          // zero length
    send_item(CMD_APPEND, 48'd16, 49'd32, '0, 8'd7);       // gap then owned
    send_item(CMD_APPEND, 48'd20, 49'd40, '0, 8'd8);       // out of order
    send_item(CMD_APPEND, 48'd40, 49'd40, '0, 8'd8);       // empty region
    send_item(CMD_APPEND, 48'd40, 49'd50, '0, HOLE_CODE);  // hole owner
    send_item(CMD_APPEND, 48'd32, 49'd33, '0, 8'hFF);      // adjacent
    send_item(CMD_APPEND, 48'd40, ADDR_CAP + 49'd1, '0, 8'd1); // past end
    send_item(CMD_LOOKUP, 48'd3, '0, '0, '0);
    send_item(CMD_LOOKUP, 48'd16, '0, '0, '0);
    send_item(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
    send_item(CMD_MAXGAP, '0, '0, '0, '0);
    send_item(CMD_FIT, 48'd2, 49'd40, 49'd10, '0);
    send_item(CMD_FIT, 48'd0, 49'd16, 49'd17, '0);         // no fit
    send_item(CMD_APPEND, 48'h7FFF_FFFF_FFFF, ADDR_CAP, '0, 8'd0);
    send_item(CMD_FIT, 48'd0, ADDR_CAP, ADDR_CAP, '0);
    send_item(CMD_BOGUS, 48'hFFFF_FFFF_FFFF, '1, '1, 8'hFF);
    send_item(CMD_SKIP, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    drain();
  endtask

  // Fill the table past its slot count so appends report full.
  task automatic test_full_table();
    logic [48:0] at;
    at = '0;
    for (int i = 0; i < 40; i++) begin
      at += $urandom_range(1, 3);
      send_item(CMD_APPEND, at[47:0], at + 49'd1, '0, rand_owner());
      at += 1;
    end
    send_item(CMD_MAXGAP, '0, '0, '0, '0);
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    drain();
  endtask

  // Random phase: mostly well-formed ascending append runs with queries.
  task automatic test_random(int n, logic [48:0] span);
    logic [48:0] at, lo, hi, step, ra;
    int kind;
    at = '0;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      ra = rand49();
      if (kind < 3) begin
        send_item(CMD_CLEAR, ra[47:0], rand49(), rand49(), 8'($urandom()));
        at = '0;
      end else if (kind < 40) begin
        step = (span >> $urandom_range(6, 12)) + 1;
        lo = at + (($urandom_range(0, 1) == 1) ? $urandom_range(0, 32'hFFFF) % step : 0);
        hi = lo + 1 + $urandom_range(0, 32'hFFFF) % step;
        if (kind < 6) hi = rand49();        // malformed end
        send_item(CMD_APPEND, lo[47:0], hi,
                  rand49(), (kind == 7) ? HOLE_CODE : rand_owner());
        if (hi > at && hi <= span) at = hi;
      end else if (kind < 60) begin
        lo = (kind < 57) ? $urandom_range(0, 32'hFFFF) % (at + 4) : rand49();
        send_item(CMD_LOOKUP, lo[47:0], rand49(), rand49(), 8'($urandom()));
      end else if (kind < 68) begin
        send_item(CMD_MAXGAP, ra[47:0], rand49(), rand49(), 8'($urandom()));
      end else if (kind < 97) begin
        lo = $urandom_range(0, 32'hFFFF) % (at + 8);
        hi = lo + $urandom_range(0, 32'hFFFF) % (span / 4 + 2);
        if (kind < 72) hi = rand49();
        send_item(CMD_FIT, lo[47:0], hi, 49'($urandom_range(0, 40)), 8'($urandom()));
      end else begin
        send_item(3'($urandom_range(5, 7)), ra[47:0], rand49(), rand49(),
                  8'($urandom()));
      end
    end
    send_item(CMD_CLEAR, '0, '0, '0, '0);
    drain();
  endtask

  // Long receiver hold-off while items keep coming: input must stall.
  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 12; i++)
      send_item(CMD_LOOKUP, 48'($urandom_range(0, 1000)), '0, '0, '0);
    drain();
  endtask

  // Domain end lowered after appends: clipping, and zero domain.
  task automatic test_shrunk_domain();
    send_item(CMD_APPEND, 48'd100, 49'd200, '0, 8'd3);
    send_item(CMD_APPEND, 48'd400, 49'd500, '0, 8'd4);
    drain();
    write_domain_end(49'd300);
    test_random(60, 49'd300);
    write_domain_end(49'd0);
    send_item(CMD_MAXGAP, '0, '0, '0, '0);
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_APPEND, '0, 49'd1, '0, 8'd1);
    send_item(CMD_FIT, '0, 49'd1, 49'd1, '0);
    drain();
    write_domain_end('1);   // oversized acts as full range
    send_item(CMD_MAXGAP, '0, '0, '0, '0);
    send_item(CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, '0, '0, '0);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_shrunk_domain();
    write_domain_end(49'd1);
    test_random(60, 49'd1);
    write_domain_end(49'd5000);
    test_random(500, 49'd5000);
    write_domain_end(ADDR_CAP);
    test_random(500, ADDR_CAP);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    test_random(250, 49'd100000);
    if (!failed && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
